/* rtl/core/nmr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmr_pkg
// Shared types, constants and helpers for the neighbour mode recolour core.
// ----------------------------------------------------------------------------
package nmr_pkg;

  localparam int unsigned RGB_W            = 24;
  localparam int unsigned NB_N             = 8;
  localparam int unsigned NB_IDX_W         = 3;
  localparam int unsigned REG_SLOTS        = 3;
  localparam int unsigned CNT_W            = 2;
  localparam int unsigned WIN_W            = 4;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 24;
  localparam int unsigned CHANGE_SLOTS_DEF = 3;
  localparam int unsigned IGNORE_SLOTS_DEF = 3;

  typedef logic [RGB_W-1:0]                rgb_t;
  typedef logic [REG_SLOTS-1:0][RGB_W-1:0] rgb_set_t;
  typedef logic [WIN_W-1:0]                win_cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANGE_COUNT   = 3'd0,
    REG_CHANGE_COLOR_0 = 3'd1,
    REG_CHANGE_COLOR_1 = 3'd2,
    REG_CHANGE_COLOR_2 = 3'd3,
    REG_IGNORE_COUNT   = 3'd4,
    REG_IGNORE_COLOR_0 = 3'd5,
    REG_IGNORE_COLOR_1 = 3'd6,
    REG_IGNORE_COLOR_2 = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [REG_SLOTS-1:0] change_en;
    rgb_set_t             change_color;
    logic [REG_SLOTS-1:0] ignore_en;
    rgb_set_t             ignore_color;
  } color_sets_t;

  function automatic logic in_set(rgb_t c, rgb_set_t set, logic [REG_SLOTS-1:0] en);
    logic hit;
    hit = 1'b0;
    for (int s = 0; s < REG_SLOTS; s++) begin
      if (en[s] && (set[s] == c)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

/* rtl/core/nmr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmr_if
// Valid/ready channels for pixel windows in and recoloured pixels out.
// ----------------------------------------------------------------------------
interface nmr_in_if;
  import nmr_pkg::*;

  logic                valid;
  logic                ready;
  rgb_t                centre_rgb;
  rgb_t                nb_up_left;
  rgb_t                nb_up;
  rgb_t                nb_up_right;
  rgb_t                nb_left;
  rgb_t                nb_right;
  rgb_t                nb_down_left;
  rgb_t                nb_down;
  rgb_t                nb_down_right;
  logic [NB_N-1:0]     inside_mask;

  modport source (
    output valid, centre_rgb, nb_up_left, nb_up, nb_up_right, nb_left, nb_right,
           nb_down_left, nb_down, nb_down_right, inside_mask,
    input  ready
  );

  modport sink (
    input  valid, centre_rgb, nb_up_left, nb_up, nb_up_right, nb_left, nb_right,
           nb_down_left, nb_down, nb_down_right, inside_mask,
    output ready
  );
endinterface

interface nmr_out_if;
  import nmr_pkg::*;

  logic     valid;
  logic     ready;
  rgb_t     result_rgb;
  logic     replaced;
  win_cnt_t winner_count;

  modport source (
    output valid, result_rgb, replaced, winner_count,
    input  ready
  );

  modport sink (
    input  valid, result_rgb, replaced, winner_count,
    output ready
  );
endinterface

/* rtl/core/nmr_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmr_cfg
// Change and ignore colour registers with their slot enables.
// ----------------------------------------------------------------------------
module nmr_cfg #(
  parameter int unsigned CHANGE_SLOTS = nmr_pkg::CHANGE_SLOTS_DEF,
  parameter int unsigned IGNORE_SLOTS = nmr_pkg::IGNORE_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nmr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nmr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output nmr_pkg::color_sets_t             sets_o
);
  import nmr_pkg::*;

  localparam int unsigned ChgN = (CHANGE_SLOTS < REG_SLOTS) ? CHANGE_SLOTS : REG_SLOTS;
  localparam int unsigned IgnN = (IGNORE_SLOTS < REG_SLOTS) ? IGNORE_SLOTS : REG_SLOTS;

  logic [CNT_W-1:0] change_count_q;
  logic [CNT_W-1:0] ignore_count_q;
  rgb_t             change_color_q [ChgN];
  rgb_t             ignore_color_q [IgnN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      change_count_q <= '0;
      ignore_count_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_CHANGE_COUNT) begin
        change_count_q <= cfg_data_i[CNT_W-1:0];
      end
      if (cfg_idx_i == REG_IGNORE_COUNT) begin
        ignore_count_q <= cfg_data_i[CNT_W-1:0];
      end
    end
  end

  for (genvar s = 0; s < REG_SLOTS; s++) begin : g_change
    if (s < ChgN) begin : g_on
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          change_color_q[s] <= '0;
        end else if (cfg_we_i &&
                     (cfg_idx_i == CFG_IDX_W'(int'(REG_CHANGE_COLOR_0) + s))) begin
          change_color_q[s] <= cfg_data_i[RGB_W-1:0];
        end
      end
      assign sets_o.change_color[s] = change_color_q[s];
      assign sets_o.change_en[s]    = (change_count_q > CNT_W'(s));
    end else begin : g_off
      assign sets_o.change_color[s] = '0;
      assign sets_o.change_en[s]    = 1'b0;
    end
  end

  for (genvar s = 0; s < REG_SLOTS; s++) begin : g_ignore
    if (s < IgnN) begin : g_on
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          ignore_color_q[s] <= '0;
        end else if (cfg_we_i &&
                     (cfg_idx_i == CFG_IDX_W'(int'(REG_IGNORE_COLOR_0) + s))) begin
          ignore_color_q[s] <= cfg_data_i[RGB_W-1:0];
        end
      end
      assign sets_o.ignore_color[s] = ignore_color_q[s];
      assign sets_o.ignore_en[s]    = (ignore_count_q > CNT_W'(s));
    end else begin : g_off
      assign sets_o.ignore_color[s] = '0;
      assign sets_o.ignore_en[s]    = 1'b0;
    end
  end

endmodule

/* rtl/core/neighbour_mode_recolour_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_mode_recolour_core
// 3x3 neighbour mode filter that recolours centre pixels of selected colours.
// ----------------------------------------------------------------------------
// One pixel window is taken per clock while in_i.ready is high, and each
// gives exactly one result through a four-stage pipeline: colour set matching,
// pairwise neighbour compare with running counts, maximum count, then winner
// select into the output register. Each stage holds its item when the stage
// after it is full and stalled, so bubbles close up under backpressure. Colour
// registers are to be written only while the pipeline is empty.
module neighbour_mode_recolour_core #(
  parameter int unsigned CHANGE_SLOTS = nmr_pkg::CHANGE_SLOTS_DEF,
  parameter int unsigned IGNORE_SLOTS = nmr_pkg::IGNORE_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  nmr_in_if.sink                         in_i,
  nmr_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [nmr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nmr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import nmr_pkg::*;

  color_sets_t sets;

  nmr_cfg #(
    .CHANGE_SLOTS (CHANGE_SLOTS),
    .IGNORE_SLOTS (IGNORE_SLOTS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sets_o     (sets)
  );

  // stage advance
  logic adv1, adv2, adv3, adv4;
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;

  assign adv4 = !s4_valid_q || out_o.ready;
  assign adv3 = !s3_valid_q || adv4;
  assign adv2 = !s2_valid_q || adv3;
  assign adv1 = !s1_valid_q || adv2;
  assign in_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_i.valid;
      if (adv2) s2_valid_q <= s1_valid_q;
      if (adv3) s3_valid_q <= s2_valid_q;
      if (adv4) s4_valid_q <= s3_valid_q;
    end
  end

  // stage 1: colour set matching
  rgb_t            nb_in [NB_N];
  logic [NB_N-1:0] ok_d;
  logic            chg_d;

  assign nb_in[0] = in_i.nb_up_left;
  assign nb_in[1] = in_i.nb_up;
  assign nb_in[2] = in_i.nb_up_right;
  assign nb_in[3] = in_i.nb_left;
  assign nb_in[4] = in_i.nb_right;
  assign nb_in[5] = in_i.nb_down_left;
  assign nb_in[6] = in_i.nb_down;
  assign nb_in[7] = in_i.nb_down_right;

  always_comb begin
    chg_d = in_set(in_i.centre_rgb, sets.change_color, sets.change_en);
    for (int k = 0; k < NB_N; k++) begin
      ok_d[k] = in_i.inside_mask[k] &&
                !in_set(nb_in[k], sets.change_color, sets.change_en) &&
                !in_set(nb_in[k], sets.ignore_color, sets.ignore_en);
    end
  end

  rgb_t            s1_centre_q;
  rgb_t            s1_nb_q [NB_N];
  logic [NB_N-1:0] s1_ok_q;
  logic            s1_chg_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_centre_q <= in_i.centre_rgb;
      s1_nb_q     <= nb_in;
      s1_ok_q     <= ok_d;
      s1_chg_q    <= chg_d;
    end
  end

  // stage 2: running count of each neighbour colour in raster order
  win_cnt_t cnt_d [NB_N];

  always_comb begin
    for (int k = 0; k < NB_N; k++) begin
      cnt_d[k] = '0;
      for (int j = 0; j < NB_N; j++) begin
        if ((j <= k) && s1_ok_q[k] && s1_ok_q[j] && (s1_nb_q[j] == s1_nb_q[k])) begin
          cnt_d[k] = cnt_d[k] + WIN_W'(1);
        end
      end
    end
  end

  rgb_t     s2_centre_q;
  rgb_t     s2_nb_q  [NB_N];
  win_cnt_t s2_cnt_q [NB_N];
  logic     s2_chg_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_centre_q <= s1_centre_q;
      s2_nb_q     <= s1_nb_q;
      s2_cnt_q    <= cnt_d;
      s2_chg_q    <= s1_chg_q;
    end
  end

  // stage 3: best count
  win_cnt_t max_d;

  always_comb begin
    max_d = '0;
    for (int k = 0; k < NB_N; k++) begin
      if (s2_cnt_q[k] > max_d) begin
        max_d = s2_cnt_q[k];
      end
    end
  end

  rgb_t     s3_centre_q;
  rgb_t     s3_nb_q  [NB_N];
  win_cnt_t s3_cnt_q [NB_N];
  win_cnt_t s3_max_q;
  logic     s3_chg_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      s3_centre_q <= s2_centre_q;
      s3_nb_q     <= s2_nb_q;
      s3_cnt_q    <= s2_cnt_q;
      s3_max_q    <= max_d;
      s3_chg_q    <= s2_chg_q;
    end
  end

  // stage 4: earliest neighbour that reached the best count
  logic [NB_IDX_W-1:0] sel_d;
  logic                hit_d;

  always_comb begin
    sel_d = '0;
    for (int k = NB_N - 1; k >= 0; k--) begin
      if (s3_cnt_q[k] == s3_max_q) begin
        sel_d = NB_IDX_W'(k);
      end
    end
    hit_d = s3_chg_q && (s3_max_q != '0);
  end

  rgb_t     s4_rgb_q;
  logic     s4_replaced_q;
  win_cnt_t s4_count_q;

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      s4_rgb_q      <= hit_d ? s3_nb_q[sel_d] : s3_centre_q;
      s4_replaced_q <= hit_d;
      s4_count_q    <= hit_d ? s3_max_q : '0;
    end
  end

  assign out_o.valid        = s4_valid_q;
  assign out_o.result_rgb   = s4_rgb_q;
  assign out_o.replaced     = s4_replaced_q;
  assign out_o.winner_count = s4_count_q;

endmodule
